// ===== src/assert_macros.svh =====
// Assertion macros for the im2col RTL; included by im2col_back.
// Included by modules that check their own logic; expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define IM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define IM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/im2col_pkg.sv =====
// Types and constants of the im2col patch unroller.
// No dependencies; imported by every module of the block.
package im2col_pkg;

  localparam int MapDepth   = 4096;
  localparam int MapAw      = $clog2(MapDepth);
  localparam int PtrW       = MapAw + 1;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);
  // element address before the store range check: (255*255 + 3840) * 255 + 3840
  localparam int AddrW      = 26;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_LOAD  = 2'd1,
    OP_EMIT  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_CHANNELS      = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_IMAGE_WIDTH   = 3'd2,
    REG_KERNEL_HEIGHT = 3'd3,
    REG_KERNEL_WIDTH  = 3'd4,
    REG_STEP_SIZE     = 3'd5
  } reg_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_ADDR,
    BK_READ,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    logic [7:0] channels;
    logic [7:0] image_height;
    logic [7:0] image_width;
    logic [3:0] kernel_height;
    logic [3:0] kernel_width;
    logic [3:0] step_size;
  } cfg_t;

  typedef struct packed {
    op_e                kind;
    logic signed [15:0] sample;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] element;
    logic [15:0]        matrix_row;
    logic [15:0]        matrix_col;
    logic               row_end;
    logic               matrix_end;
    status_e            status;
  } res_t;

endpackage

// ===== src/im2col_front.sv =====
// Front end of the im2col block: accepts requests, sorts out undefined ones
// and queues the rest for the back end. Depends on im2col_pkg.
module im2col_front
  import im2col_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic [1:0]         s_op_i,
  input  logic signed [15:0] s_sample_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output cmd_t               cmd_o
);

  cmd_t             q_mem [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  op_e              op;
  logic             keep, push, pop;

  assign op = op_e'(s_op_i);

  always_comb begin
    unique case (op)
      OP_BEGIN, OP_LOAD, OP_EMIT: keep = 1'b1;
      OP_NONE:                    keep = 1'b0;
      default:                    keep = 1'b0;
    endcase
  end

  assign s_ready_o   = (cnt_q != QCntW'(QueueDepth));
  assign push        = s_valid_i && s_ready_o && keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= '{kind: op, sample: s_sample_i};
    end
  end

endmodule

// ===== src/im2col_back.sv =====
// Back end of the im2col block: feature map store, emit counters, address
// pipeline and output register. Depends on im2col_pkg and assert_macros.svh.
`include "assert_macros.svh"

module im2col_back
  import im2col_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  cmd_valid_i,
  output logic  cmd_ready_o,
  input  cmd_t  cmd_i,
  output logic  m_valid_o,
  input  logic  m_ready_i,
  output res_t  res_o
);

  back_state_e state_q, state_d;

  logic signed [15:0] map_mem [MapDepth];
  logic signed [15:0] rdata_q;
  logic               inrange_q;

  logic [PtrW-1:0] ld_ptr_q, ld_ptr_d;
  logic            ovf_q, ovf_d, done_q, done_d;
  logic [7:0]      out_y_q, out_y_d, out_x_q, out_x_d, chan_q, chan_d;
  logic [3:0]      ker_y_q, ker_y_d, ker_x_q, ker_x_d;
  logic [15:0]     row_cnt_q, row_cnt_d, col_cnt_q, col_cnt_d;

  logic pop, do_begin, do_load, mem_wr, rd_en, out_free, out_fire;

  // multiply stage
  logic [3:0]  stride;
  logic [11:0] oys, oxs, hin_d, win_d;
  logic [15:0] ca_d;
  logic        empty, oob, exh_d, set_done;
  logic        lkx_d, lky_d, lc_d, lox_d, loy_d;
  logic [11:0] hin_q, win_q;
  logic [15:0] ca_q;
  logic        exh_q, lkx_q, lky_q, lc_q, lox_q, loy_q;

  logic [16:0]      row_base;
  logic [AddrW-1:0] addr_d, addr_q;
  logic             r_end, m_end;

  logic        out_valid_q, out_valid_d;
  res_t        res_q;

  // ---------------- control ----------------
  assign out_free    = !out_valid_q || m_ready_i;
  assign cmd_ready_o = (state_q == BK_IDLE);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign do_begin    = pop && (cmd_i.kind == OP_BEGIN);
  assign do_load     = pop && (cmd_i.kind == OP_LOAD);
  assign mem_wr      = do_load && (ld_ptr_q < PtrW'(MapDepth));
  assign rd_en       = (state_q == BK_READ);
  assign out_fire    = (state_q == BK_OUT) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (pop && (cmd_i.kind == OP_EMIT)) state_d = BK_MUL;
      BK_MUL:  state_d = exh_d ? BK_OUT : BK_ADDR;
      BK_ADDR: state_d = BK_READ;
      BK_READ: state_d = BK_OUT;
      BK_OUT:  if (out_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // ---------------- multiply stage ----------------
  always_comb begin
    stride = (cfg_i.step_size == '0) ? 4'd1 : cfg_i.step_size;
    oys    = 12'(out_y_q) * 12'(stride);
    oxs    = 12'(out_x_q) * 12'(stride);
    hin_d  = oys + 12'(ker_y_q);
    win_d  = oxs + 12'(ker_x_q);
    ca_d   = 16'(chan_q) * 16'(cfg_i.image_height);
    empty  = (cfg_i.channels == '0) || (cfg_i.kernel_height == '0) ||
             (cfg_i.kernel_width == '0) ||
             (8'(cfg_i.kernel_height) > cfg_i.image_height) ||
             (8'(cfg_i.kernel_width) > cfg_i.image_width);
    // out_y >= H_out  <=>  out_y*s + kh > ih, same for x
    oob    = ((13'(oys) + 13'(cfg_i.kernel_height)) > 13'(cfg_i.image_height)) ||
             ((13'(oxs) + 13'(cfg_i.kernel_width)) > 13'(cfg_i.image_width)) ||
             (chan_q >= cfg_i.channels) ||
             (ker_y_q >= cfg_i.kernel_height) ||
             (ker_x_q >= cfg_i.kernel_width);
    exh_d    = done_q || empty || oob;
    set_done = !done_q && !empty && oob;
    lkx_d  = (5'(ker_x_q) + 5'd1) >= 5'(cfg_i.kernel_width);
    lky_d  = (5'(ker_y_q) + 5'd1) >= 5'(cfg_i.kernel_height);
    lc_d   = (9'(chan_q) + 9'd1) >= 9'(cfg_i.channels);
    lox_d  = (13'(oxs) + 13'(stride) + 13'(cfg_i.kernel_width)) >
             13'(cfg_i.image_width);
    loy_d  = (13'(oys) + 13'(stride) + 13'(cfg_i.kernel_height)) >
             13'(cfg_i.image_height);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_MUL) begin
      hin_q <= hin_d;
      win_q <= win_d;
      ca_q  <= ca_d;
      exh_q <= exh_d;
      lkx_q <= lkx_d;
      lky_q <= lky_d;
      lc_q  <= lc_d;
      lox_q <= lox_d;
      loy_q <= loy_d;
    end
  end

  // ---------------- address stage ----------------
  assign row_base = 17'(ca_q) + 17'(hin_q);
  assign addr_d   = AddrW'(row_base) * AddrW'(cfg_i.image_width) + AddrW'(win_q);

  always_ff @(posedge clk_i) begin
    if (state_q == BK_ADDR) begin
      addr_q <= addr_d;
    end
  end

  // ---------------- store ----------------
  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      map_mem[ld_ptr_q[MapAw-1:0]] <= cmd_i.sample;
    end
    if (rd_en) begin
      rdata_q   <= map_mem[addr_q[MapAw-1:0]];
      inrange_q <= (addr_q < AddrW'(MapDepth));
    end
  end

  // ---------------- counters ----------------
  assign r_end = lkx_q && lky_q && lc_q;
  assign m_end = r_end && lox_q && loy_q;

  always_comb begin
    ld_ptr_d  = ld_ptr_q;
    ovf_d     = ovf_q;
    done_d    = done_q;
    out_y_d   = out_y_q;
    out_x_d   = out_x_q;
    chan_d    = chan_q;
    ker_y_d   = ker_y_q;
    ker_x_d   = ker_x_q;
    row_cnt_d = row_cnt_q;
    col_cnt_d = col_cnt_q;
    if (do_begin) begin
      ld_ptr_d  = '0;
      ovf_d     = 1'b0;
      done_d    = 1'b0;
      out_y_d   = '0;
      out_x_d   = '0;
      chan_d    = '0;
      ker_y_d   = '0;
      ker_x_d   = '0;
      row_cnt_d = '0;
      col_cnt_d = '0;
    end
    if (do_load) begin
      if (mem_wr) ld_ptr_d = ld_ptr_q + 1'b1;
      else        ovf_d    = 1'b1;
    end
    if ((state_q == BK_MUL) && set_done) begin
      done_d = 1'b1;
    end
    if (out_fire && !exh_q) begin
      if (m_end) begin
        done_d = 1'b1;
      end else begin
        col_cnt_d = col_cnt_q + 1'b1;
        if (!lkx_q) begin
          ker_x_d = ker_x_q + 1'b1;
        end else begin
          ker_x_d = '0;
          if (!lky_q) begin
            ker_y_d = ker_y_q + 1'b1;
          end else begin
            ker_y_d = '0;
            if (!lc_q) begin
              chan_d = chan_q + 1'b1;
            end else begin
              chan_d    = '0;
              col_cnt_d = '0;
              row_cnt_d = row_cnt_q + 1'b1;
              if (!lox_q) begin
                out_x_d = out_x_q + 1'b1;
              end else begin
                out_x_d = '0;
                out_y_d = out_y_q + 1'b1;
              end
            end
          end
        end
      end
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_fire)       out_valid_d = 1'b1;
    else if (m_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      if (exh_q) begin
        res_q <= '{element: '0, matrix_row: '0, matrix_col: '0,
                   row_end: 1'b0, matrix_end: 1'b0, status: ST_EXHAUSTED};
      end else begin
        res_q <= '{element: inrange_q ? rdata_q : 16'sd0,
                   matrix_row: row_cnt_q, matrix_col: col_cnt_q,
                   row_end: r_end, matrix_end: m_end,
                   status: ovf_q ? ST_OVERFLOW : ST_OK};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      ld_ptr_q    <= '0;
      ovf_q       <= 1'b0;
      done_q      <= 1'b0;
      out_y_q     <= '0;
      out_x_q     <= '0;
      chan_q      <= '0;
      ker_y_q     <= '0;
      ker_x_q     <= '0;
      row_cnt_q   <= '0;
      col_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ld_ptr_q    <= ld_ptr_d;
      ovf_q       <= ovf_d;
      done_q      <= done_d;
      out_y_q     <= out_y_d;
      out_x_q     <= out_x_d;
      chan_q      <= chan_d;
      ker_y_q     <= ker_y_d;
      ker_x_q     <= ker_x_d;
      row_cnt_q   <= row_cnt_d;
      col_cnt_q   <= col_cnt_d;
    end
  end

  assign m_valid_o = out_valid_q;
  assign res_o     = res_q;

  // ---------------- assertions ----------------
  `IM_ASSERT(a_ptr_bound, ld_ptr_q <= PtrW'(MapDepth), "load pointer past store depth")
  `IM_ASSERT(a_ovf_full, ovf_q |-> (ld_ptr_q == PtrW'(MapDepth)), "overflow with room left")
  `IM_ASSERT(a_mend_rend, (out_valid_q && res_q.matrix_end) |-> res_q.row_end, "matrix end without row end")
  `IM_ASSERT(a_exh_zero, (out_valid_q && (res_q.status == ST_EXHAUSTED)) |-> ((res_q.element == 16'sd0) && (res_q.matrix_row == '0) && (res_q.matrix_col == '0) && !res_q.row_end), "exhausted result not cleared")
  `IM_ASSERT(a_done_at_end, (out_fire && !exh_q && m_end) |=> done_q, "done not set after last element")

endmodule

// ===== src/im2col_patch_unroller.sv =====
// Top level of the im2col patch unroller: stream ports, APB register file,
// front and back ends. Depends on im2col_pkg, im2col_front and im2col_back.
//
// Use: the slave stream carries requests; tuser is the operation (begin frame,
// load, emit), tdata the sample. Begin a frame, load the feature map in channel,
// row, column order, then send one emit request per matrix element wanted.
// Each emit yields one result on the master stream: tdata holds element,
// matrix row and matrix column, tlast marks the end of a matrix row, tuser holds
// the end-of-matrix flag and the status. Begin and load requests yield nothing.
// Throughput: requests enter a two-entry queue at one per cycle while it has
// room; the back end retires a begin or load as it pops it, and runs an emit
// through queue pop, stride multiply, address multiply-add, store read and
// output load, an exhausted emit skipping the address and read steps. The emit
// rate is set by that sequential address pipeline and the single store port.
// A stalled master side holds the result register; the back end then waits in
// its output step while the queue keeps taking requests until it fills.
// Reset: registers return to their reset values, counters and flags clear;
// the store is not cleared and holds garbage until loaded.
module im2col_patch_unroller
  import im2col_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] element, [31:16] matrix_row, [47:32] matrix_col
  output logic        m_axis_tlast,   // row_end
  output logic [2:0]  m_axis_tuser,   // [0] matrix_end, [2:1] status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_q, cfg_d;
  reg_e reg_idx;
  logic cfg_wr;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  // APB register file; always ready, written in the access phase
  assign pready  = 1'b1;
  assign reg_idx = reg_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_CHANNELS:      cfg_d.channels      = pwdata[7:0];
        REG_IMAGE_HEIGHT:  cfg_d.image_height  = pwdata[7:0];
        REG_IMAGE_WIDTH:   cfg_d.image_width   = pwdata[7:0];
        REG_KERNEL_HEIGHT: cfg_d.kernel_height = pwdata[3:0];
        REG_KERNEL_WIDTH:  cfg_d.kernel_width  = pwdata[3:0];
        REG_STEP_SIZE:     cfg_d.step_size     = pwdata[3:0];
        default:           cfg_d = cfg_q;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CHANNELS:      prdata = 32'(cfg_q.channels);
      REG_IMAGE_HEIGHT:  prdata = 32'(cfg_q.image_height);
      REG_IMAGE_WIDTH:   prdata = 32'(cfg_q.image_width);
      REG_KERNEL_HEIGHT: prdata = 32'(cfg_q.kernel_height);
      REG_KERNEL_WIDTH:  prdata = 32'(cfg_q.kernel_width);
      REG_STEP_SIZE:     prdata = 32'(cfg_q.step_size);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{channels: 8'd1, image_height: 8'd28, image_width: 8'd28,
                 kernel_height: 4'd5, kernel_width: 4'd5, step_size: 4'd1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // accept and classify requests, queue them for the back end
  im2col_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_op_i      (s_axis_tuser),
    .s_sample_i  (s_axis_tdata),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // run requests in order against the store and the emit counters
  im2col_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .res_o       (res)
  );

  // pack the result fields onto the stream
  assign m_axis_tdata = {res.matrix_col, res.matrix_row, res.element};
  assign m_axis_tlast = res.row_end;
  assign m_axis_tuser = {res.status, res.matrix_end};

endmodule

// ===== bench/im2col_matrix_checker.sv =====
// Result checker for the im2col patch unroller: watches the request, result and
// register ports, predicts each matrix element and compares. Depends on im2col_pkg.
`timescale 1ns / 1ps

module im2col_matrix_checker
  import im2col_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // [15:0] element, [31:16] matrix_row, [47:32] matrix_col
  input  logic        m_axis_tlast,   // row_end
  input  logic [2:0]  m_axis_tuser,   // [0] matrix_end, [2:1] status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatch_count_o,
  output int          pending_o,
  output int          checked_o
);

  cfg_t        geom;
  logic [15:0] map_copy [MapDepth];
  int unsigned fill_ptr;
  bit          overflow_seen;
  bit          matrix_done;
  int unsigned pos_y, pos_x, chan, kern_y, kern_x;
  logic [15:0] row_idx, col_idx;
  res_t        pending_elements [$];
  res_t        got, want;

  function automatic void restart_frame();
    fill_ptr      = 0;
    overflow_seen = 1'b0;
    matrix_done   = 1'b0;
    pos_y         = 0;
    pos_x         = 0;
    chan          = 0;
    kern_y        = 0;
    kern_x        = 0;
    row_idx       = '0;
    col_idx       = '0;
  endfunction

  // Walk the nested counters one element forward and return the element taken.
  function automatic res_t next_matrix_element();
    res_t        r;
    int unsigned stride, h_out, w_out, addr;
    bit          last_kx, last_ky, last_c, last_ox, last_oy;
    r        = '0;
    r.status = ST_EXHAUSTED;
    stride   = (geom.step_size == 0) ? 1 : geom.step_size;
    if (matrix_done || geom.channels == 0 || geom.kernel_height == 0 ||
        geom.kernel_width == 0 || geom.kernel_height > geom.image_height ||
        geom.kernel_width > geom.image_width)
      return r;
    h_out = (geom.image_height - geom.kernel_height) / stride + 1;
    w_out = (geom.image_width - geom.kernel_width) / stride + 1;
    // counters left outside a changed geometry end the matrix
    if (pos_y >= h_out || pos_x >= w_out || chan >= geom.channels ||
        kern_y >= geom.kernel_height || kern_x >= geom.kernel_width) begin
      matrix_done = 1'b1;
      return r;
    end
    addr = (chan * geom.image_height + pos_y * stride + kern_y) * geom.image_width +
           pos_x * stride + kern_x;
    r.element = (addr < MapDepth) ? map_copy[addr] : 16'h0000;
    last_kx   = (kern_x + 1 >= geom.kernel_width);
    last_ky   = (kern_y + 1 >= geom.kernel_height);
    last_c    = (chan + 1 >= geom.channels);
    last_ox   = (pos_x + 1 >= w_out);
    last_oy   = (pos_y + 1 >= h_out);
    r.matrix_row = row_idx;
    r.matrix_col = col_idx;
    r.row_end    = last_kx && last_ky && last_c;
    r.matrix_end = r.row_end && last_ox && last_oy;
    r.status     = overflow_seen ? ST_OVERFLOW : ST_OK;
    if (r.matrix_end) begin
      matrix_done = 1'b1;
      return r;
    end
    col_idx++;
    if (!last_kx) begin
      kern_x++;
    end else begin
      kern_x = 0;
      if (!last_ky) begin
        kern_y++;
      end else begin
        kern_y = 0;
        if (!last_c) begin
          chan++;
        end else begin
          chan    = 0;
          col_idx = '0;
          row_idx++;
          if (!last_ox) begin
            pos_x++;
          end else begin
            pos_x = 0;
            pos_y++;
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom = '{channels: 8'd1, image_height: 8'd28, image_width: 8'd28,
               kernel_height: 4'd5, kernel_width: 4'd5, step_size: 4'd1};
      restart_frame();
      pending_elements.delete();
      mismatch_count_o = 0;
      checked_o        = 0;
      pending_o        = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_e'(paddr[4:2]))
          REG_CHANNELS:      geom.channels      = pwdata[7:0];
          REG_IMAGE_HEIGHT:  geom.image_height  = pwdata[7:0];
          REG_IMAGE_WIDTH:   geom.image_width   = pwdata[7:0];
          REG_KERNEL_HEIGHT: geom.kernel_height = pwdata[3:0];
          REG_KERNEL_WIDTH:  geom.kernel_width  = pwdata[3:0];
          REG_STEP_SIZE:     geom.step_size     = pwdata[3:0];
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got.element    = m_axis_tdata[15:0];
        got.matrix_row = m_axis_tdata[31:16];
        got.matrix_col = m_axis_tdata[47:32];
        got.row_end    = m_axis_tlast;
        got.matrix_end = m_axis_tuser[0];
        got.status     = status_e'(m_axis_tuser[2:1]);
        checked_o++;
        if (pending_elements.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%0t: result with no emit request waiting: element %0d row %0d col %0d",
                     $time, got.element, got.matrix_row, got.matrix_col);
        end else begin
          want = pending_elements.pop_front();
          if (got.element !== want.element || got.matrix_row !== want.matrix_row ||
              got.matrix_col !== want.matrix_col || got.row_end !== want.row_end ||
              got.matrix_end !== want.matrix_end || got.status !== want.status) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $write("%0t: mismatch, expected element %0d row %0d col %0d",
                     $time, want.element, want.matrix_row, want.matrix_col);
              $write(" last %0b end %0b status %0d,",
                     want.row_end, want.matrix_end, want.status);
              $write(" got element %0d row %0d col %0d",
                     got.element, got.matrix_row, got.matrix_col);
              $display(" last %0b end %0b status %0d",
                       got.row_end, got.matrix_end, got.status);
            end
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        case (op_e'(s_axis_tuser))
          OP_BEGIN: restart_frame();
          OP_LOAD: begin
            if (fill_ptr < MapDepth) begin
              map_copy[fill_ptr] = s_axis_tdata;
              fill_ptr++;
            end else begin
              overflow_seen = 1'b1;
            end
          end
          OP_EMIT: pending_elements.push_back(next_matrix_element());
          default: ;
        endcase
      end
      pending_o = pending_elements.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the im2col patch unroller bench: clock, reset, request and register
// stimulus, result sink and verdict. Depends on im2col_pkg, the block and im2col_matrix_checker.
`timescale 1ns / 1ps

module testbench;
  import im2col_pkg::*;

  localparam int RandomItems = 1450;
  localparam int DrainCycles = 20;   // queue of two plus the five-step emit path, with margin
  localparam int LongHold    = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] sample
  logic [1:0]  s_axis_tuser = '0;   // [1:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [15:0] element, [31:16] matrix_row, [47:32] matrix_col
  logic        m_axis_tlast;        // row_end
  logic [2:0]  m_axis_tuser;        // [0] matrix_end, [2:1] status
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches, pending, checked;

  // Idling switch shared by both sides, and the one-shot long receiver hold-off.
  bit idle_en  = 1'b1;
  bit hold_req = 1'b0;

  // Stimulus-side view of the geometry and of how much of the store holds data.
  // Loads always start at slot zero, so the written part is a prefix.
  int unsigned c_ch = 1, c_ih = 28, c_iw = 28, c_kh = 5, c_kw = 5, c_st = 1;
  int unsigned written_len = 0;
  int unsigned next_slot = 0;
  int unsigned sent_requests = 0;
  int unsigned frames_run = 0;
  int unsigned settings_run = 0;
  // Request count from which the closing stretch runs with no idling.
  int unsigned calm_after = 32'hFFFF_FFFF;

  logic [15:0] corner_samples [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                                      16'h5555, 16'hAAAA};

  im2col_patch_unroller DUT (.*);

  im2col_matrix_checker checker_u (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatch_count_o(mismatches),
    .pending_o(pending),
    .checked_o(checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs or results go missing.
  initial begin
    #12ms;
    $display("testbench: errors");
    $finish;
  end

  // Number of im2col matrix elements for a geometry; zero when the matrix is empty.
  function automatic int unsigned matrix_len(input int unsigned ch, ih, iw, kh, kw, st);
    int unsigned stride;
    stride = (st == 0) ? 1 : st;
    if (ch == 0 || kh == 0 || kw == 0 || kh > ih || kw > iw) return 0;
    return ((ih - kh) / stride + 1) * ((iw - kw) / stride + 1) * ch * kh * kw;
  endfunction

  // An emit may read any slot of the current frame; allow it only once every slot
  // inside the store has been written at some point.
  function automatic bit map_covered();
    int unsigned need;
    need = c_ch * c_ih * c_iw;
    if (need > MapDepth) need = MapDepth;
    return matrix_len(c_ch, c_ih, c_iw, c_kh, c_kw, c_st) == 0 || written_len >= need;
  endfunction

  // Favor the sign, zero and all-ones corners now and then.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one request, optionally after an idle burst, and hold it until taken.
  task automatic push_request(input op_e op, input logic [15:0] smp);
    if (sent_requests >= calm_after) idle_en = 1'b0;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
    case (op)
      OP_BEGIN: next_slot = 0;
      OP_LOAD: begin
        if (next_slot < MapDepth) next_slot++;
        if (next_slot > written_len) written_len = next_slot;
      end
      default: ;
    endcase
    if (op != OP_NONE) sent_requests++;
  endtask

  // Drop valid and hold until every emitted element has come back.
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Results alone do not prove the back end is done with trailing loads: drain too.
  task automatic wait_idle();
    wait_results();
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Setup then access phase; psel stays high across back-to-back writes.
  task automatic apb_write(input reg_e idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input int unsigned ch, ih, iw, kh, kw, st);
    wait_idle();
    apb_write(REG_CHANNELS, ch);
    apb_write(REG_IMAGE_HEIGHT, ih);
    apb_write(REG_IMAGE_WIDTH, iw);
    apb_write(REG_KERNEL_HEIGHT, kh);
    apb_write(REG_KERNEL_WIDTH, kw);
    apb_write(REG_STEP_SIZE, st);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    c_ch = ch & 8'hFF;
    c_ih = ih & 8'hFF;
    c_iw = iw & 8'hFF;
    c_kh = kh & 4'hF;
    c_kw = kw & 4'hF;
    c_st = st & 4'hF;
    settings_run++;
  endtask

  // Keep frames small so a full matrix stays a few hundred elements.
  task automatic random_geometry();
    int unsigned ch, ih, iw, kh, kw, st;
    do begin
      ch = $urandom_range(1, 3);
      ih = $urandom_range(1, 10);
      iw = $urandom_range(1, 10);
      kh = $urandom_range(1, 4);
      kw = $urandom_range(1, 4);
      st = $urandom_range(0, 4);
    end while (ch * ih * iw > 200 || matrix_len(ch, ih, iw, kh, kw, st) > 300);
    set_geometry(ch, ih, iw, kh, kw, st);
  endtask

  // Well-formed frame: begin, load the map, then request matrix elements.
  task automatic run_frame(input int unsigned loads, input int unsigned emits,
                           input bit pause_midway);
    push_request(OP_BEGIN, pick_sample());
    repeat (loads) push_request(OP_LOAD, pick_sample());
    for (int unsigned i = 0; i < emits; i++) begin
      if (pause_midway && i == emits / 2) wait_results();
      push_request(OP_EMIT, pick_sample());
    end
    frames_run++;
  endtask

  // Noise: random operations, partial frames; emits only where the map is covered.
  task automatic run_noise(input int unsigned count);
    op_e op;
    repeat (count) begin
      op = op_e'($urandom_range(0, 3));
      if (op == OP_BEGIN && $urandom_range(0, 3) != 0) op = OP_LOAD;
      if (op == OP_EMIT && !map_covered()) op = OP_LOAD;
      push_request(op, pick_sample());
    end
  endtask

  // Result side: random tready bursts, plus one long hold-off that lets the
  // request queue fill and stall the sender.
  initial begin : result_sink
    bit held;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int unsigned episode, random_goal, total, emits, burst_start;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: an ignored operation, a tiny frame with the sample extremes, the
    // full matrix and one emit past its end.
    push_request(OP_NONE, 16'hFFFF);
    set_geometry(1, 2, 3, 2, 2, 1);
    push_request(OP_BEGIN, 16'h0000);
    foreach (corner_samples[i]) push_request(OP_LOAD, corner_samples[i]);
    repeat (9) push_request(OP_EMIT, pick_sample());
    push_request(OP_NONE, 16'h0000);
    frames_run++;

    random_goal = sent_requests + RandomItems;
    episode = 0;
    while (sent_requests < random_goal) begin
      // Let the closing stretch run with no idling on either side.
      calm_after = random_goal - 150;
      idle_en = (random_goal - sent_requests > 150) && ($urandom_range(0, 4) != 0);
      if (episode == 12) begin
        // Overfill the store: 8192-word frame, 4096 slots. Every element reports
        // overflow, and channel one lies beyond the store and reads zero.
        burst_start = sent_requests;
        set_geometry(2, 64, 64, 1, 1, 15);
        run_frame(MapDepth + 5, matrix_len(c_ch, c_ih, c_iw, c_kh, c_kw, c_st) + 2, 1'b0);
        random_goal += sent_requests - burst_start;
      end else begin
        case (episode)
          0: begin
            set_geometry(255, 1, 1, 1, 1, 15);
            hold_req = 1'b1;
          end
          1:  set_geometry(1, 255, 1, 15, 1, 15);
          2:  set_geometry(1, 1, 255, 1, 15, 15);
          3:  set_geometry(1, 15, 15, 15, 15, 1);
          4:  set_geometry(2, 5, 7, 3, 2, 0);      // stride zero acts as one
          5:  set_geometry(0, 4, 4, 2, 2, 1);      // no channels: empty matrix
          6:  set_geometry(1, 3, 3, 0, 2, 1);      // zero kernel height
          7:  set_geometry(1, 3, 3, 2, 0, 1);      // zero kernel width
          8:  set_geometry(1, 0, 4, 1, 1, 1);      // zero image height
          9:  set_geometry(1, 4, 0, 1, 1, 1);      // zero image width
          10: set_geometry(1, 4, 4, 5, 2, 1);      // kernel taller than image
          11: set_geometry(3, 6, 5, 2, 3, 2);
          default: if ($urandom_range(0, 2) == 0) random_geometry();
        endcase
        // Emit before a new frame: picks up the old counters under the new geometry.
        if (map_covered() && $urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 4)) push_request(OP_EMIT, pick_sample());
        if (episode > 12 && $urandom_range(0, 4) == 0) begin
          run_noise($urandom_range(5, 30));
        end else begin
          total = matrix_len(c_ch, c_ih, c_iw, c_kh, c_kw, c_st);
          if (total == 0)
            emits = $urandom_range(1, 3);
          else if ($urandom_range(0, 4) == 0)
            emits = $urandom_range(1, total);   // leave the matrix unfinished
          else
            emits = total + $urandom_range(0, 2);
          run_frame(c_ch * c_ih * c_iw, emits, episode == 1 || $urandom_range(0, 9) == 0);
        end
      end
      episode++;
    end

    wait_results();
    repeat (DrainCycles) @(posedge clk_i);
    $display("run covered %0d requests in %0d frames over %0d register settings,",
             sent_requests, frames_run, settings_run);
    $display("  %0d matrix elements compared, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && pending == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
